FILE: hw/rtl/bfsc_pkg.sv
// shared types, codes and constants of the bulk frame sequence checker
package bfsc_pkg;

   // largest payload that counts towards the byte total
   localparam int unsigned MAX_FRAME_BYTES = 65535;

   // command queue between front and back
   localparam int unsigned CMDQ_DEPTH = 4;
   localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

   // configuration register indexes
   localparam logic [7:0] CSR_MAX_ERROR_RUN    = 8'd0;
   localparam logic [7:0] CSR_DELIVERY_ENABLED = 8'd1;

   // input status codes
   localparam logic [1:0] STATUS_VALID   = 2'd0;
   localparam logic [1:0] STATUS_NO_DATA = 2'd1;

   // frame kinds
   localparam logic [2:0] KIND_START = 3'd0;
   localparam logic [2:0] KIND_DATA  = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_RESET = 3'd3;

   // result codes
   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_START = 3'd1;
   localparam logic [2:0] EV_DATA  = 3'd2;
   localparam logic [2:0] EV_STOP  = 3'd3;
   localparam logic [2:0] EV_RESET = 3'd4;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_ORDER    = 3'd1;
   localparam logic [2:0] ERR_LOST     = 3'd2;
   localparam logic [2:0] ERR_UNKNOWN  = 3'd3;
   localparam logic [2:0] ERR_READ     = 3'd4;

   localparam logic [1:0] WARN_NONE         = 2'd0;
   localparam logic [1:0] WARN_BEFORE_DATA  = 2'd1;
   localparam logic [1:0] WARN_WHILE_STOP   = 2'd2;
   localparam logic [1:0] WARN_NO_START     = 2'd3;

   // frame class decided by the front
   typedef enum logic [2:0] {
      CLS_IGNORE,
      CLS_READ_ERR,
      CLS_START,
      CLS_DATA,
      CLS_STOP,
      CLS_RESET,
      CLS_UNKNOWN
   } cls_type;

   typedef struct packed {
      logic [1:0]  sample_status;
      logic [2:0]  frame_kind;
      logic [31:0] frames_remaining;
      logic [15:0] payload_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [2:0]  error_kind;
      logic [1:0]  stop_warning;
      logic [31:0] frames_seen;
      logic [31:0] frames_expected;
      logic [15:0] delivered_bytes;
      logic [7:0]  error_run_out;
      logic        error_alert;
      logic [1:0]  mode_out;
   } rsp_type;

   typedef struct packed {
      cls_type     cls;
      logic [31:0] remaining;
      logic [15:0] pay;
   } cmd_type;

   typedef struct packed {
      logic [7:0] max_error_run;
      logic       delivery_enabled;
   } cfg_type;

endpackage

FILE: hw/rtl/bulk_frame_sequence_checker.sv
// top level of the bulk frame sequence checker
//
// Request side is a queue input: a frame header on req_data is taken at a
// rising edge with req_push high and req_full low. Each request yields exactly
// one result, read from the rsp side like a queue: rsp_data holds the oldest
// result while rsp_empty is low and it leaves at an edge with rsp_pop high.
// Requests pass through a four-entry command queue in the front; the back
// takes one command a cycle while the result buffer has room or is popped,
// updates the sequence state and writes the result into a two-entry result
// buffer. A taken request is registered in the command queue; once the back
// takes it, its result is registered in the result buffer and can be popped.
// When the receiver stops popping the result buffer fills, the back holds,
// the command queue fills and req_full rises; nothing is lost.
// The csr port (always ready) writes max_error_run at index 0 and
// delivery_enabled at index 1; other indexes are ignored. Reset (synchronous,
// active high) empties both queues, returns to the start mode with all
// counters cleared and loads the limit of four and delivery on.
module bulk_frame_sequence_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bfsc_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bfsc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import bfsc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   cmd_type cmd_head;
   logic    cmd_take;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_ERROR_RUN:    cfg_in.max_error_run    = csr_wdata;
            CSR_DELIVERY_ENABLED: cfg_in.delivery_enabled = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_error_run    <= 8'd4;
         cfg_ff.delivery_enabled <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify
   bfsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_take  (cmd_take)
   );

   // back: sequence checking and results
   bfsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/bfsc_front.sv
// front end: accepts requests, classifies them and queues the commands
module bfsc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bfsc_pkg::req_type req_data,
   output logic              cmd_valid,
   output bfsc_pkg::cmd_type cmd_head,
   input  logic              cmd_take
);
   import bfsc_pkg::*;

   cmd_type              cmd_new;
   cmd_type              queue_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_take;

   // classify the request
   always_comb begin
      cmd_new.remaining = req_data.frames_remaining;
      if ({16'd0, req_data.payload_bytes} > 32'(MAX_FRAME_BYTES)) begin
         cmd_new.pay = 16'(MAX_FRAME_BYTES);
      end else begin
         cmd_new.pay = req_data.payload_bytes;
      end
      if (req_data.sample_status == STATUS_NO_DATA) begin
         cmd_new.cls = CLS_IGNORE;
      end else if (req_data.sample_status != STATUS_VALID) begin
         cmd_new.cls = CLS_READ_ERR;
      end else begin
         case (req_data.frame_kind)
            KIND_START: cmd_new.cls = CLS_START;
            KIND_DATA:  cmd_new.cls = CLS_DATA;
            KIND_STOP:  cmd_new.cls = CLS_STOP;
            KIND_RESET: cmd_new.cls = CLS_RESET;
            default:    cmd_new.cls = CLS_UNKNOWN;
         endcase
      end
   end

   // queue control
   assign req_full  = (count_ff == CMDQ_CW'(CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_head  = queue_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_take   = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CMDQ_CW'(do_push) - CMDQ_CW'(do_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

FILE: hw/rtl/bfsc_back.sv
// back end: sequence state, result build and two-entry result buffer
module bfsc_back (
   input  logic              clock,
   input  logic              reset,
   input  bfsc_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  bfsc_pkg::cmd_type cmd_head,
   output logic              cmd_take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bfsc_pkg::rsp_type rsp_data
);
   import bfsc_pkg::*;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_RECV,
      MODE_STOPPED,
      MODE_IGNORE
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [31:0] byte_total_ff, byte_total_in;
   logic [31:0] frame_counter_ff, frame_counter_in;
   logic [31:0] frame_total_ff, frame_total_in;
   logic [31:0] next_rem_ff, next_rem_in;
   logic [7:0]  error_run_ff, error_run_in;

   rsp_type     res_in;
   rsp_type     obuf_ff [2];
   logic        owr_ff, owr_in;
   logic        ord_ff, ord_in;
   logic [1:0]  ocount_ff, ocount_in;
   logic        do_pop;
   logic        fire;

   logic [7:0]  run_inc;
   logic        alert_inc;
   logic        first_data;
   logic [32:0] byte_sum;
   logic [31:0] byte_sat;
   logic        lost;

   // result buffer handshake
   assign rsp_empty = (ocount_ff == 2'd0);
   assign rsp_data  = obuf_ff[ord_ff];
   assign do_pop    = rsp_pop && !rsp_empty;
   assign fire      = cmd_valid && ((ocount_ff != 2'd2) || do_pop);
   assign cmd_take  = fire;

   // shared helpers for the step
   always_comb begin
      run_inc    = (error_run_ff == 8'hff) ? 8'hff : error_run_ff + 8'd1;
      alert_inc  = (run_inc >= cfg.max_error_run);
      first_data = (byte_total_ff == 32'd0);
      byte_sum   = {1'b0, byte_total_ff} + {17'd0, cmd_head.pay};
      byte_sat   = byte_sum[32] ? 32'hffff_ffff : byte_sum[31:0];
      lost       = (cmd_head.remaining != 32'd0) && (next_rem_ff != 32'd0)
                   && (next_rem_ff != cmd_head.remaining);
   end

   // sequence step
   always_comb begin
      mode_in          = mode_ff;
      byte_total_in    = byte_total_ff;
      frame_counter_in = frame_counter_ff;
      frame_total_in   = frame_total_ff;
      next_rem_in      = next_rem_ff;
      error_run_in     = error_run_ff;
      res_in           = '0;

      case (cmd_head.cls)
         CLS_IGNORE: begin
         end
         CLS_READ_ERR: begin
            res_in.error_kind = ERR_READ;
            error_run_in      = run_inc;
         end
         CLS_UNKNOWN: begin
            res_in.error_kind = ERR_UNKNOWN;
            error_run_in      = run_inc;
         end
         CLS_START: begin
            if (mode_ff != MODE_RECV) begin
               byte_total_in    = '0;
               frame_counter_in = '0;
               mode_in          = MODE_RECV;
               res_in.event_res = cfg.delivery_enabled ? EV_START : EV_NONE;
               error_run_in     = '0;
            end else begin
               res_in.error_kind  = ERR_ORDER;
               res_in.error_alert = alert_inc;
               error_run_in       = run_inc;
            end
         end
         CLS_DATA: begin
            if (mode_ff == MODE_RECV) begin
               frame_total_in   = first_data ? cmd_head.remaining + 32'd1
                                             : frame_total_ff;
               frame_counter_in = (first_data ? 32'd0 : frame_counter_ff) + 32'd1;
               if (cmd_head.remaining == 32'd0) begin
                  byte_total_in = '0;
               end else begin
                  byte_total_in = byte_sat;
               end
               if (lost) begin
                  res_in.error_kind  = ERR_LOST;
                  res_in.error_alert = alert_inc;
                  error_run_in       = run_inc;
               end else begin
                  if (cmd_head.remaining != 32'd0) begin
                     next_rem_in = cmd_head.remaining - 32'd1;
                  end
                  if (cfg.delivery_enabled) begin
                     res_in.event_res       = EV_DATA;
                     res_in.delivered_bytes = cmd_head.pay;
                  end
                  error_run_in = '0;
               end
            end else if (mode_ff != MODE_IGNORE) begin
               res_in.error_kind = ERR_ORDER;
               mode_in           = MODE_IGNORE;
            end
         end
         CLS_STOP: begin
            if (mode_ff == MODE_RECV) begin
               mode_in = MODE_STOPPED;
               if (frame_counter_ff == 32'd0) begin
                  res_in.stop_warning = WARN_BEFORE_DATA;
               end else if (frame_counter_ff != frame_total_ff) begin
                  res_in.error_kind  = ERR_LOST;
                  res_in.error_alert = alert_inc;
               end
            end else if (mode_ff == MODE_STOPPED) begin
               res_in.stop_warning = WARN_WHILE_STOP;
            end else begin
               res_in.stop_warning = WARN_NO_START;
            end
            res_in.event_res = cfg.delivery_enabled ? EV_STOP : EV_NONE;
            error_run_in     = '0;
         end
         CLS_RESET: begin
            res_in.event_res = cfg.delivery_enabled ? EV_RESET : EV_NONE;
            mode_in          = MODE_STOPPED;
            byte_total_in    = '0;
            frame_counter_in = '0;
            frame_total_in   = '0;
            next_rem_in      = '0;
            error_run_in     = '0;
         end
         default: begin
         end
      endcase

      res_in.frames_seen     = frame_counter_in;
      res_in.frames_expected = frame_total_in;
      res_in.error_run_out   = error_run_in;
      res_in.mode_out        = mode_in;
   end

   // result buffer pointers
   always_comb begin
      owr_in    = fire ? !owr_ff : owr_ff;
      ord_in    = do_pop ? !ord_ff : ord_ff;
      ocount_in = ocount_ff + 2'(fire) - 2'(do_pop);
   end

   // state and buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_START;
         byte_total_ff    <= '0;
         frame_counter_ff <= '0;
         frame_total_ff   <= '0;
         next_rem_ff      <= '0;
         error_run_ff     <= '0;
         owr_ff           <= 1'b0;
         ord_ff           <= 1'b0;
         ocount_ff        <= '0;
      end else begin
         if (fire) begin
            mode_ff          <= mode_in;
            byte_total_ff    <= byte_total_in;
            frame_counter_ff <= frame_counter_in;
            frame_total_ff   <= frame_total_in;
            next_rem_ff      <= next_rem_in;
            error_run_ff     <= error_run_in;
         end
         owr_ff    <= owr_in;
         ord_ff    <= ord_in;
         ocount_ff <= ocount_in;
      end
   end

   // result buffer storage
   always_ff @(posedge clock) begin
      if (fire) begin
         obuf_ff[owr_ff] <= res_in;
      end
   end

endmodule
